// File: hw/rtl/line_editor_field_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Line editor field tokenizer: assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef LINE_EDITOR_FIELD_TOKENIZER_MACROS_SVH
`define LINE_EDITOR_FIELD_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lft_pkg.sv
// ----------------------------------------------------------------------------
// lft_pkg
// Constants, types and character helpers for the line editor field tokenizer.
// ----------------------------------------------------------------------------
package lft_pkg;

  // Sizing
  localparam int LINE_CHARS  = 80;
  localparam int FIELD_LIMIT = 5;
  localparam int CNT_W  = $clog2(LINE_CHARS + 1);
  localparam int ADDR_W = $clog2(LINE_CHARS);
  localparam int FCNT_W = $clog2(FIELD_LIMIT + 1);
  localparam int FLD_W  = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;

  // Record field widths
  localparam int IDX_W  = 3;
  localparam int POS_W  = 7;
  localparam int CNTO_W = 3;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_AMP   = 8'h26;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic rd;      // read next stored character
    logic load;    // load next record into output register
  } lft_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic line_done;  // accepted character ends the line
    logic rd_more;    // characters remain to be read
    logic out_free;   // output register can take a record
    logic last_rec;   // current record is the final one
  } lft_sts_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) ? c + 8'd32 : c;
  endfunction

endpackage

// File: hw/rtl/lft_datapath.sv
// ----------------------------------------------------------------------------
// lft_datapath
// Line store, edit counter, field scan and record output register.
// ----------------------------------------------------------------------------
module lft_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               rx_char,
  input  lft_pkg::lft_cmd_t        cmd,
  output lft_pkg::lft_sts_t        sts,
  input  logic                     rec_stall,
  output logic                     rec_valid,
  output logic [lft_pkg::IDX_W-1:0]  field_index,
  output logic [lft_pkg::POS_W-1:0]  field_position,
  output logic                     field_type,
  output logic [lft_pkg::CNTO_W-1:0] field_count,
  output logic [lft_pkg::POS_W-1:0]  line_length,
  output logic                     no_fields,
  output logic                     last
);

  logic [7:0]                  line_store [lft_pkg::LINE_CHARS];
  logic [7:0]                  rd_data;
  logic [lft_pkg::CNT_W-1:0]   char_count;
  logic [lft_pkg::CNT_W-1:0]   line_len;
  logic [lft_pkg::CNT_W-1:0]   rd_pos;
  logic [lft_pkg::CNT_W-1:0]   data_pos;
  logic                        data_vld;
  logic                        prev_alnum;
  logic [lft_pkg::FCNT_W-1:0]  found;
  logic [lft_pkg::FCNT_W-1:0]  emit_k;
  logic [lft_pkg::CNT_W-1:0]   start_tab [lft_pkg::FIELD_LIMIT];
  logic                        type_tab  [lft_pkg::FIELD_LIMIT];

  logic is_bs, is_cr, is_prn, line_full, finish, store;
  logic d_letter, d_digit, d_amp, d_alnum, field_hit, none;
  logic line_done, rd_more, out_free, last_rec;
  logic [lft_pkg::FLD_W-1:0] kidx;

  // Decode the incoming character
  always_comb begin
    is_bs     = (rx_char == lft_pkg::CH_BS) || (rx_char == lft_pkg::CH_DEL);
    is_cr     = (rx_char == lft_pkg::CH_CR);
    is_prn    = (rx_char >= lft_pkg::CH_SPACE) && !is_bs;
    line_full = (char_count == lft_pkg::CNT_W'(lft_pkg::LINE_CHARS - 1));
    line_done = is_cr || (is_prn && line_full);
    finish    = cmd.accept && line_done;
    store     = cmd.accept && is_prn;
  end

  // Edit the character count; clear it when the line ends
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
    end else if (finish) begin
      char_count <= '0;
    end else if (cmd.accept) begin
      if (is_bs) begin
        if (char_count != '0) char_count <= char_count - 1'b1;
      end else if (is_prn) begin
        char_count <= char_count + 1'b1;
      end
    end
  end

  // Capture the finished line length
  always_ff @(posedge clk) begin
    if (finish) begin
      line_len <= is_cr ? char_count : lft_pkg::CNT_W'(lft_pkg::LINE_CHARS);
    end
  end

  // Line store: write on edit, registered read during scan
  always_ff @(posedge clk) begin
    if (store) begin
      line_store[char_count[lft_pkg::ADDR_W-1:0]] <= lft_pkg::to_lower(rx_char);
    end
    if (cmd.rd) begin
      rd_data <= line_store[rd_pos[lft_pkg::ADDR_W-1:0]];
    end
  end

  // Advance the read pointer
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      rd_pos <= '0;
    end else if (cmd.rd) begin
      rd_pos <= rd_pos + 1'b1;
    end
  end

  assign rd_more = (rd_pos < line_len);

  // Track which read data is valid and where it came from
  always_ff @(posedge clk) begin
    if (rst) begin
      data_vld <= 1'b0;
    end else begin
      data_vld <= cmd.rd;
    end
    if (cmd.rd) data_pos <= rd_pos;
  end

  // Classify the character and detect a field start
  always_comb begin
    d_letter  = lft_pkg::is_letter(rd_data);
    d_digit   = lft_pkg::is_digit(rd_data);
    d_amp     = (rd_data == lft_pkg::CH_AMP);
    d_alnum   = d_letter || d_digit;
    field_hit = data_vld &&
                ((data_pos == '0) ? d_alnum : (!prev_alnum && (d_alnum || d_amp))) &&
                (found < lft_pkg::FCNT_W'(lft_pkg::FIELD_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (data_vld) prev_alnum <= d_alnum;
  end

  // Count fields found in this line
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      found <= '0;
    end else if (field_hit) begin
      found <= found + 1'b1;
    end
  end

  // Record field start and type
  always_ff @(posedge clk) begin
    if (field_hit) begin
      start_tab[found[lft_pkg::FLD_W-1:0]] <= data_pos;
      type_tab[found[lft_pkg::FLD_W-1:0]]  <= d_digit;
    end
  end

  // Step through the records
  always_ff @(posedge clk) begin
    if (rst || finish) begin
      emit_k <= '0;
    end else if (cmd.load) begin
      emit_k <= emit_k + 1'b1;
    end
  end

  always_comb begin
    none     = (found == '0);
    kidx     = emit_k[lft_pkg::FLD_W-1:0];
    last_rec = none || ((emit_k + 1'b1) == found);
    out_free = !rec_valid || !rec_stall;
  end

  // Report status to the controller
  assign sts = '{line_done: line_done, rd_more: rd_more,
                 out_free: out_free, last_rec: last_rec};

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (cmd.load) begin
      rec_valid <= 1'b1;
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      field_index    <= none ? '0 : lft_pkg::IDX_W'(emit_k);
      field_position <= none ? '0 : lft_pkg::POS_W'(start_tab[kidx]);
      field_type     <= !none && type_tab[kidx];
      field_count    <= lft_pkg::CNTO_W'(found);
      line_length    <= lft_pkg::POS_W'(line_len);
      no_fields      <= none;
      last           <= last_rec;
    end
  end

endmodule

// File: hw/rtl/lft_ctrl.sv
// ----------------------------------------------------------------------------
// lft_ctrl
// Sequencer: edit, scan the finished line, drain the read, emit records.
// ----------------------------------------------------------------------------
module lft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  lft_pkg::lft_sts_t sts,
  output lft_pkg::lft_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Commands
  always_comb begin
    rx_stall   = (state != S_IDLE);
    cmd.accept = (state == S_IDLE) && rx_valid;
    cmd.rd     = (state == S_SCAN) && sts.rd_more;
    cmd.load   = (state == S_EMIT) && sts.out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept && sts.line_done) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.rd_more) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (cmd.load && sts.last_rec) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/line_editor_field_tokenizer.sv
// ----------------------------------------------------------------------------
// line_editor_field_tokenizer
// Line editor that tokenizes each finished line into field records.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (rx_valid/rx_stall/rx_char): one character per transfer.
//   Backspace or delete drops the last stored character; codes 32 and up
//   are stored in lower case; other control codes are ignored.
//   Carriage return, or the line store filling up, ends the line.
//   rec channel (rec_valid/rec_stall): one record per field found, up to
//   the field limit, or a single no_fields record; last marks the final one.
//   Ordinary characters are taken one per cycle while rx_stall is low. A line
//   end holds rx_stall high while the scan reads the stored characters, one
//   per cycle, from the line store, drains the last read, and then loads the
//   records one at a time into the output register.
//   The output register parts the sides: after the last record is loaded,
//   characters are taken again while it waits. A stalled receiver holds
//   the record steady and delays the next one.
//   Reset clears counts and handshakes; store contents stay undefined.
// ----------------------------------------------------------------------------
module line_editor_field_tokenizer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rx_valid,
  output logic                        rx_stall,
  input  logic [7:0]                  rx_char,
  output logic                        rec_valid,
  input  logic                        rec_stall,
  output logic [lft_pkg::IDX_W-1:0]   field_index,
  output logic [lft_pkg::POS_W-1:0]   field_position,
  output logic                        field_type,
  output logic [lft_pkg::CNTO_W-1:0]  field_count,
  output logic [lft_pkg::POS_W-1:0]   line_length,
  output logic                        no_fields,
  output logic                        last
);

  lft_pkg::lft_cmd_t cmd;
  lft_pkg::lft_sts_t sts;

  // Sequencer
  lft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, scan and output register
  lft_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .rx_char        (rx_char),
    .cmd            (cmd),
    .sts            (sts),
    .rec_stall      (rec_stall),
    .rec_valid      (rec_valid),
    .field_index    (field_index),
    .field_position (field_position),
    .field_type     (field_type),
    .field_count    (field_count),
    .line_length    (line_length),
    .no_fields      (no_fields),
    .last           (last)
  );

endmodule

// File: hw/rtl/lft_checker.sv
// ----------------------------------------------------------------------------
// lft_checker
// Port-level checks on the record stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_editor_field_tokenizer_macros.svh"

module lft_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rec_valid,
  input logic                        rec_stall,
  input logic [lft_pkg::IDX_W-1:0]   field_index,
  input logic [lft_pkg::POS_W-1:0]   field_position,
  input logic [lft_pkg::CNTO_W-1:0]  field_count,
  input logic [lft_pkg::POS_W-1:0]   line_length,
  input logic                        no_fields,
  input logic                        last
);

  // Hold a stalled record
  `LFT_ASSERT_NEXT(a_hold, clk, rst, rec_valid && rec_stall, rec_valid && $stable(field_index) && $stable(field_position), "stalled record changed")

  // Fieldless record stands alone
  `LFT_ASSERT_IMPLY(a_none, clk, rst, rec_valid && no_fields, last && (field_count == '0), "no_fields record malformed")

  // Index stays below the count
  `LFT_ASSERT_IMPLY(a_idx, clk, rst, rec_valid && !no_fields, field_index < field_count, "field index out of range")

  // Final record carries the highest index
  `LFT_ASSERT_IMPLY(a_last, clk, rst, rec_valid && !no_fields && last, field_index == (field_count - 1'b1), "last marker misplaced")

  // Field starts inside the line
  `LFT_ASSERT_IMPLY(a_pos, clk, rst, rec_valid && !no_fields, field_position < line_length, "field start past line end")

endmodule

bind line_editor_field_tokenizer lft_checker u_lft_checker (
  .clk            (clk),
  .rst            (rst),
  .rec_valid      (rec_valid),
  .rec_stall      (rec_stall),
  .field_index    (field_index),
  .field_position (field_position),
  .field_count    (field_count),
  .line_length    (line_length),
  .no_fields      (no_fields),
  .last           (last)
);
